FILE: hdl/shtf_pkg.sv
// shtf_pkg: shared types, request codes and constants of the telemetry framer.
// No dependencies; used by every module of the block.
`default_nettype none
package shtf_pkg;

  localparam logic [2:0] REQ_RAW  = 3'd0;
  localparam logic [2:0] REQ_CELL = 3'd1;
  localparam logic [2:0] REQ_FUEL = 3'd2;
  localparam logic [2:0] REQ_LAT  = 3'd3;
  localparam logic [2:0] REQ_LON  = 3'd4;
  localparam logic [2:0] REQ_STOP = 3'd5;

  localparam logic [7:0] HDR_BYTE  = 8'h5E;
  localparam logic [7:0] ESC_BYTE  = 8'h5D;
  localparam logic [7:0] ESC_XOR   = 8'h60;
  localparam logic [7:0] STOP_BYTE = 8'h5E;

  localparam logic [7:0] ID_FUEL    = 8'h04;
  localparam logic [7:0] ID_CELL    = 8'h06;
  localparam logic [7:0] ID_LON_INT = 8'h12;
  localparam logic [7:0] ID_LON_DEC = 8'h1A;
  localparam logic [7:0] ID_LON_HEM = 8'h22;
  localparam logic [7:0] ID_LAT_INT = 8'h13;
  localparam logic [7:0] ID_LAT_DEC = 8'h1B;
  localparam logic [7:0] ID_LAT_HEM = 8'h23;

  localparam logic [7:0] LETTER_N = 8'h4E;
  localparam logic [7:0] LETTER_S = 8'h53;
  localparam logic [7:0] LETTER_E = 8'h45;
  localparam logic [7:0] LETTER_W = 8'h57;

  localparam logic [11:0] CELL_MAX = 12'd2100;

  localparam logic [9:0] FUEL_TH_100 = 10'd94;
  localparam logic [9:0] FUEL_TH_75  = 10'd69;
  localparam logic [9:0] FUEL_TH_50  = 10'd44;
  localparam logic [9:0] FUEL_TH_25  = 10'd19;

  // floor(m / 100000) = ((m >> 5) * DIV1_MAGIC) >> 39 for any 32-bit m
  localparam logic [27:0] DIV1_MAGIC = 28'd175921861;
  localparam int          DIV1_SHIFT = 39;
  localparam logic [16:0] INT_SCALE  = 17'd100000;
  // floor(r / 10) = ((r >> 1) * DIV2_MAGIC) >> 19 for r < 2^17
  localparam logic [16:0] DIV2_MAGIC = 17'd104858;
  localparam int          DIV2_SHIFT = 19;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic        stop;
    logic        last;
    logic [7:0]  id;
    logic [15:0] value;
  } rec_t;

endpackage
`default_nettype wire

FILE: hdl/sensor_hub_telemetry_framer.sv
// sensor_hub_telemetry_framer: top level of the telemetry record framer.
// Depends on shtf_pkg, shtf_front, shtf_rec_fifo, shtf_back.
//
//   channel | ports                              | handshake
//   input   | in_req_type .. in_coordinate       | in_valid / in_ready
//   output  | out_byte, out_last_byte            | out_valid / out_ready
//
// Output runs at one byte per cycle while out_ready is high.
// A request yields 0 to 18 bytes. Front: position requests run through
// S_DIV1 to S_DIV3, then push one record per cycle while the queue has room.
// Sustained rate is set by the byte serializer: 4 to 6 bytes per record,
// one byte for a stop record.
// Synchronous active-low reset clears all control state; no clearing pass.
// The record queue lets the front run ahead while the output is stalled.
`default_nettype none
module sensor_hub_telemetry_framer #(
  parameter int QUEUE_DEPTH = shtf_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [7:0]         in_value_id,
  input  wire logic [15:0]        in_raw_value,
  input  wire logic [7:0]         in_cell_index,
  input  wire logic [11:0]        in_cell_level,
  input  wire logic [9:0]         in_fuel_percent,
  input  wire logic signed [31:0] in_coordinate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last_byte
);

  logic           push_valid, push_ready, rd_valid, rd_en;
  shtf_pkg::rec_t push_rec, rd_rec;

  shtf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_value_id     (in_value_id),
    .in_raw_value    (in_raw_value),
    .in_cell_index   (in_cell_index),
    .in_cell_level   (in_cell_level),
    .in_fuel_percent (in_fuel_percent),
    .in_coordinate   (in_coordinate),
    .push_valid      (push_valid),
    .push_rec        (push_rec),
    .push_ready      (push_ready)
  );

  shtf_rec_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_rec   (push_rec),
    .wr_ready (push_ready),
    .rd_valid (rd_valid),
    .rd_rec   (rd_rec),
    .rd_en    (rd_en)
  );

  shtf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_valid      (rd_valid),
    .rd_rec        (rd_rec),
    .rd_en         (rd_en),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
`default_nettype wire

FILE: hdl/shtf_front.sv
// shtf_front: accepts requests, classifies them and turns each into records.
// Position requests go through a short multiply-based divide sequence.
// Depends on shtf_pkg.
`default_nettype none
module shtf_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_req_type,
  input  wire logic [7:0]         in_value_id,
  input  wire logic [15:0]        in_raw_value,
  input  wire logic [7:0]         in_cell_index,
  input  wire logic [11:0]        in_cell_level,
  input  wire logic [9:0]         in_fuel_percent,
  input  wire logic signed [31:0] in_coordinate,
  output logic                    push_valid,
  output shtf_pkg::rec_t          push_rec,
  input  wire logic               push_ready
);

  typedef enum logic [6:0] {
    S_DISPATCH = 7'b0000001,
    S_DIV1     = 7'b0000010,
    S_DIV2     = 7'b0000100,
    S_DIV3     = 7'b0001000,
    S_INT      = 7'b0010000,
    S_DEC      = 7'b0100000,
    S_HEM      = 7'b1000000
  } fstate_t;

  fstate_t     st_r, st_nxt;
  logic        h_v_r, h_v_nxt;
  logic [2:0]  h_type_r;
  logic [7:0]  h_id_r;
  logic [15:0] h_raw_r;
  logic [7:0]  h_cell_r;
  logic [11:0] h_lvl_r;
  logic [9:0]  h_fuel_r;
  logic [31:0] h_coord_r;

  logic [31:0] mag_r;
  logic        neg_r;
  logic [54:0] p1_r;
  logic [15:0] q1_r;
  logic [32:0] qm_r;
  logic [32:0] p2_r;

  logic        in_acc, fin, is_lat, is_pos, has_out;
  logic [11:0] lvl_sat;
  logic [15:0] fuel_q;
  logic [31:0] rem_full;
  logic [16:0] rem;
  shtf_pkg::rec_t simple_rec;

  assign is_lat = (h_type_r == shtf_pkg::REQ_LAT);
  assign is_pos = is_lat || (h_type_r == shtf_pkg::REQ_LON);
  assign lvl_sat = (h_lvl_r > shtf_pkg::CELL_MAX) ? shtf_pkg::CELL_MAX : h_lvl_r;
  assign rem_full = mag_r - qm_r[31:0];
  assign rem = rem_full[16:0];

  always_comb begin
    if (h_fuel_r > shtf_pkg::FUEL_TH_100) begin
      fuel_q = 16'd100;
    end else if (h_fuel_r > shtf_pkg::FUEL_TH_75) begin
      fuel_q = 16'd75;
    end else if (h_fuel_r > shtf_pkg::FUEL_TH_50) begin
      fuel_q = 16'd50;
    end else if (h_fuel_r > shtf_pkg::FUEL_TH_25) begin
      fuel_q = 16'd25;
    end else begin
      fuel_q = 16'd0;
    end
  end

  always_comb begin
    simple_rec = '{stop: 1'b0, last: 1'b1, id: h_id_r, value: h_raw_r};
    has_out = 1'b1;
    case (h_type_r)
      shtf_pkg::REQ_RAW: begin
        has_out = 1'b1;
      end
      shtf_pkg::REQ_CELL: begin
        has_out = (h_cell_r[7:4] == 4'd0);
        simple_rec.id = shtf_pkg::ID_CELL;
        simple_rec.value = {lvl_sat[7:0], h_cell_r[3:0], lvl_sat[11:8]};
      end
      shtf_pkg::REQ_FUEL: begin
        simple_rec.id = shtf_pkg::ID_FUEL;
        simple_rec.value = fuel_q;
      end
      shtf_pkg::REQ_STOP: begin
        simple_rec.stop = 1'b1;
      end
      default: begin
        has_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    fin = 1'b0;
    push_valid = 1'b0;
    push_rec = simple_rec;
    case (st_r)
      S_DISPATCH: begin
        if (h_v_r) begin
          if (is_pos) begin
            st_nxt = S_DIV1;
          end else if (has_out) begin
            push_valid = 1'b1;
            fin = push_ready;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_DIV1: st_nxt = S_DIV2;
      S_DIV2: st_nxt = S_DIV3;
      S_DIV3: st_nxt = S_INT;
      S_INT: begin
        push_valid = 1'b1;
        push_rec = '{stop: 1'b0, last: 1'b0,
                     id: is_lat ? shtf_pkg::ID_LAT_INT : shtf_pkg::ID_LON_INT,
                     value: q1_r};
        if (push_ready) begin
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        push_valid = 1'b1;
        push_rec = '{stop: 1'b0, last: 1'b0,
                     id: is_lat ? shtf_pkg::ID_LAT_DEC : shtf_pkg::ID_LON_DEC,
                     value: {2'b00, p2_r[32:shtf_pkg::DIV2_SHIFT]}};
        if (push_ready) begin
          st_nxt = S_HEM;
        end
      end
      S_HEM: begin
        push_valid = 1'b1;
        push_rec = '{stop: 1'b0, last: 1'b1,
                     id: is_lat ? shtf_pkg::ID_LAT_HEM : shtf_pkg::ID_LON_HEM,
                     value: {8'h00, is_lat ? (neg_r ? shtf_pkg::LETTER_S : shtf_pkg::LETTER_N)
                                           : (neg_r ? shtf_pkg::LETTER_W : shtf_pkg::LETTER_E)}};
        fin = push_ready;
      end
      default: st_nxt = S_DISPATCH;
    endcase
    if (fin) begin
      st_nxt = S_DISPATCH;
    end
  end

  assign in_ready = !h_v_r || fin;
  assign in_acc = in_valid && in_ready;
  assign h_v_nxt = in_acc ? 1'b1 : (fin ? 1'b0 : h_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_DISPATCH;
      h_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      h_v_r <= h_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      h_type_r <= in_req_type;
      h_id_r <= in_value_id;
      h_raw_r <= in_raw_value;
      h_cell_r <= in_cell_index;
      h_lvl_r <= in_cell_level;
      h_fuel_r <= in_fuel_percent;
      h_coord_r <= in_coordinate;
    end
    if (st_r == S_DISPATCH) begin
      neg_r <= h_coord_r[31];
      mag_r <= h_coord_r[31] ? (32'd0 - h_coord_r) : h_coord_r;
    end
    if (st_r == S_DIV1) begin
      p1_r <= 55'(mag_r[31:5]) * 55'(shtf_pkg::DIV1_MAGIC);
    end
    if (st_r == S_DIV2) begin
      q1_r <= p1_r[54:shtf_pkg::DIV1_SHIFT];
      qm_r <= 33'(p1_r[54:shtf_pkg::DIV1_SHIFT]) * 33'(shtf_pkg::INT_SCALE);
    end
    if (st_r == S_DIV3) begin
      p2_r <= 33'(rem[16:1]) * 33'(shtf_pkg::DIV2_MAGIC);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/shtf_rec_fifo.sv
// shtf_rec_fifo: short record queue between front and back.
// Depends on shtf_pkg.
`default_nettype none
module shtf_rec_fifo #(
  parameter int DEPTH = shtf_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  input  wire shtf_pkg::rec_t wr_rec,
  output logic                wr_ready,
  output logic                rd_valid,
  output shtf_pkg::rec_t      rd_rec,
  input  wire logic           rd_en
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  shtf_pkg::rec_t mem_r [DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           wr_en;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_rec = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;

  assign wp_nxt = wr_en ? ((wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
  assign rp_nxt = rd_en ? ((rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
  assign cnt_nxt = cnt_r + CW'(wr_en) - CW'(rd_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/shtf_back.sv
// shtf_back: serializes records into stuffed bytes, one beat per cycle while
// out_ready allows, through an output register. Depends on shtf_pkg.
`default_nettype none
module shtf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           rd_valid,
  input  wire shtf_pkg::rec_t rd_rec,
  output logic                rd_en,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last_byte
);

  typedef enum logic [5:0] {
    P_HDR = 6'b000001,
    P_ID  = 6'b000010,
    P_LO  = 6'b000100,
    P_LO2 = 6'b001000,
    P_HI  = 6'b010000,
    P_HI2 = 6'b100000
  } bpos_t;

  bpos_t          pos_r, pos_nxt;
  logic           cur_v_r, cur_v_nxt;
  shtf_pkg::rec_t cur_r;
  logic           out_v_r, out_v_nxt;
  logic [7:0]     out_byte_r;
  logic           out_last_r;

  logic       free, emit, done_c, last_c, lo_esc, hi_esc;
  logic [7:0] byte_c, lo, hi;
  bpos_t      step_c;

  assign lo = cur_r.value[7:0];
  assign hi = cur_r.value[15:8];
  assign lo_esc = (lo == shtf_pkg::HDR_BYTE) || (lo == shtf_pkg::ESC_BYTE);
  assign hi_esc = (hi == shtf_pkg::HDR_BYTE) || (hi == shtf_pkg::ESC_BYTE);

  always_comb begin
    byte_c = shtf_pkg::HDR_BYTE;
    last_c = 1'b0;
    done_c = 1'b0;
    step_c = pos_r;
    case (pos_r)
      P_HDR: begin
        if (cur_r.stop) begin
          byte_c = shtf_pkg::STOP_BYTE;
          last_c = cur_r.last;
          done_c = 1'b1;
        end else begin
          step_c = P_ID;
        end
      end
      P_ID: begin
        byte_c = cur_r.id;
        step_c = P_LO;
      end
      P_LO: begin
        byte_c = lo_esc ? shtf_pkg::ESC_BYTE : lo;
        step_c = lo_esc ? P_LO2 : P_HI;
      end
      P_LO2: begin
        byte_c = lo ^ shtf_pkg::ESC_XOR;
        step_c = P_HI;
      end
      P_HI: begin
        if (hi_esc) begin
          byte_c = shtf_pkg::ESC_BYTE;
          step_c = P_HI2;
        end else begin
          byte_c = hi;
          last_c = cur_r.last;
          done_c = 1'b1;
        end
      end
      P_HI2: begin
        byte_c = hi ^ shtf_pkg::ESC_XOR;
        last_c = cur_r.last;
        done_c = 1'b1;
      end
      default: step_c = P_HDR;
    endcase
  end

  assign free = !out_v_r || out_ready;
  assign emit = cur_v_r && free;
  assign rd_en = rd_valid && (!cur_v_r || (emit && done_c));
  assign cur_v_nxt = rd_en ? 1'b1 : ((emit && done_c) ? 1'b0 : cur_v_r);
  assign pos_nxt = (rd_en || (emit && done_c)) ? P_HDR : (emit ? step_c : pos_r);
  assign out_v_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= P_HDR;
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      cur_v_r <= cur_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r <= rd_rec;
    end
    if (emit) begin
      out_byte_r <= byte_c;
      out_last_r <= last_c;
    end
  end

  assign out_valid = out_v_r;
  assign out_byte = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule
`default_nettype wire

FILE: hdl/shtf_checker.sv
// shtf_checker: port-level assertions for the telemetry framer, plus bind.
// Depends on shtf_pkg and the sensor_hub_telemetry_framer ports.
`default_nettype none
module shtf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last_byte))
    else $error("output beat changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_byte != shtf_pkg::ESC_BYTE)
    else $error("escape byte marked as final beat");

endmodule

bind sensor_hub_telemetry_framer shtf_checker u_shtf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_byte      (out_byte),
  .out_last_byte (out_last_byte)
);
`default_nettype wire

FILE: tb/tb_sensor_hub_telemetry_framer.sv
// Self-checking testbench for sensor_hub_telemetry_framer: table-driven and random
// requests, per-beat byte and last checks against an in-bench framing predictor.
// Depends on shtf_pkg and the framer RTL.
`timescale 1ns / 1ps
module tb_sensor_hub_telemetry_framer;

  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam int NO_TYPED = -1;
  localparam int N_DIRECTED = 24;
  localparam int RANDOM_ITEMS = 256;
  localparam int HOLD_OFF_AT = 100;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  id;
    logic [15:0] raw;
    logic [7:0]  cell_idx;
    logic [11:0] level;
    logic [9:0]  fuel;
    logic [31:0] coord;
  } request_t;

  // typed bytes are left-aligned; n_typed of NO_TYPED means use the predictor
  typedef struct packed {
    request_t    rq;
    int          n_typed;
    logic [47:0] typed;
  } directed_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_beat_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_req_type;
  logic [7:0] in_value_id;
  logic [15:0] in_raw_value;
  logic [7:0] in_cell_index;
  logic [11:0] in_cell_level;
  logic [9:0] in_fuel_percent;
  logic signed [31:0] in_coordinate;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_byte;
  logic out_last_byte;

  stream_beat_t expected_stream[$];
  directed_row_t directed_rows [N_DIRECTED];
  int frame_len;
  int mismatch_count;
  int cycle_count;
  int accepted_items;
  int send_quiet;
  int recv_quiet;

  sensor_hub_telemetry_framer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_value_id    (in_value_id),
    .in_raw_value   (in_raw_value),
    .in_cell_index  (in_cell_index),
    .in_cell_level  (in_cell_level),
    .in_fuel_percent(in_fuel_percent),
    .in_coordinate  (in_coordinate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void push_byte(input logic [7:0] b);
    stream_beat_t sb;
    sb.data = b;
    sb.last = 1'b0;
    expected_stream.push_back(sb);
    frame_len++;
  endfunction

  function automatic void push_stuffed(input logic [7:0] b);
    if (b == shtf_pkg::HDR_BYTE || b == shtf_pkg::ESC_BYTE) begin
      push_byte(shtf_pkg::ESC_BYTE);
      push_byte(b ^ shtf_pkg::ESC_XOR);
    end else begin
      push_byte(b);
    end
  endfunction

  function automatic void push_record(input logic [7:0] id, input logic [15:0] value);
    push_byte(shtf_pkg::HDR_BYTE);
    push_byte(id);
    push_stuffed(value[7:0]);
    push_stuffed(value[15:8]);
  endfunction

  function automatic void close_frame();
    stream_beat_t tail;
    if (frame_len > 0) begin
      tail = expected_stream.pop_back();
      tail.last = 1'b1;
      expected_stream.push_back(tail);
    end
  endfunction

  function automatic void push_position(input logic [31:0] coord, input logic [7:0] id_int,
                                        input logic [7:0] id_dec, input logic [7:0] id_hem,
                                        input logic [7:0] pos_letter,
                                        input logic [7:0] neg_letter);
    logic [31:0] mag;
    logic [31:0] part;
    mag = coord[31] ? (32'd0 - coord) : coord;
    part = mag / 32'd100000;
    push_record(id_int, part[15:0]);
    part = (mag / 32'd10) % 32'd10000;
    push_record(id_dec, part[15:0]);
    push_record(id_hem, {8'h00, coord[31] ? neg_letter : pos_letter});
  endfunction

  // expected byte stream of one request
  function automatic void frame_request(input request_t r);
    logic [11:0] v;
    logic [15:0] q;
    frame_len = 0;
    case (r.req)
      shtf_pkg::REQ_RAW: push_record(r.id, r.raw);
      shtf_pkg::REQ_CELL: begin
        if (r.cell_idx <= 8'd15) begin
          v = (r.level > 12'd2100) ? 12'd2100 : r.level;
          push_record(shtf_pkg::ID_CELL, {v[7:0], r.cell_idx[3:0], v[11:8]});
        end
      end
      shtf_pkg::REQ_FUEL: begin
        if (r.fuel > 10'd94) q = 16'd100;
        else if (r.fuel > 10'd69) q = 16'd75;
        else if (r.fuel > 10'd44) q = 16'd50;
        else if (r.fuel > 10'd19) q = 16'd25;
        else q = 16'd0;
        push_record(shtf_pkg::ID_FUEL, q);
      end
      shtf_pkg::REQ_LAT:
        push_position(r.coord, shtf_pkg::ID_LAT_INT, shtf_pkg::ID_LAT_DEC,
                      shtf_pkg::ID_LAT_HEM, shtf_pkg::LETTER_N, shtf_pkg::LETTER_S);
      shtf_pkg::REQ_LON:
        push_position(r.coord, shtf_pkg::ID_LON_INT, shtf_pkg::ID_LON_DEC,
                      shtf_pkg::ID_LON_HEM, shtf_pkg::LETTER_E, shtf_pkg::LETTER_W);
      shtf_pkg::REQ_STOP: push_byte(shtf_pkg::STOP_BYTE);
      default: ;
    endcase
    close_frame();
  endfunction

  function automatic int idle_cycles(inout int quiet_left);
    int roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int sel;
    logic [31:0] m;
    r.req = shtf_pkg::REQ_RAW;
    r.id = 8'($urandom);
    r.raw = 16'($urandom);
    r.cell_idx = 8'($urandom);
    r.level = 12'($urandom);
    r.fuel = 10'($urandom);
    r.coord = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      r.req = shtf_pkg::REQ_RAW;
      if ($urandom_range(0, 2) == 0)
        r.raw[7:0] = $urandom_range(0, 1) ? shtf_pkg::HDR_BYTE : shtf_pkg::ESC_BYTE;
      if ($urandom_range(0, 2) == 0)
        r.raw[15:8] = $urandom_range(0, 1) ? shtf_pkg::HDR_BYTE : shtf_pkg::ESC_BYTE;
    end else if (sel < 42) begin
      r.req = shtf_pkg::REQ_CELL;
      if ($urandom_range(0, 99) < 85) r.cell_idx = 8'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) r.level = 12'($urandom_range(2090, 2110));
    end else if (sel < 57) begin
      r.req = shtf_pkg::REQ_FUEL;
      if ($urandom_range(0, 9) < 7) r.fuel = 10'($urandom_range(0, 120));
    end else if (sel < 87) begin
      r.req = (sel < 72) ? shtf_pkg::REQ_LAT : shtf_pkg::REQ_LON;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          m = $urandom_range(0, 1800000000);
          r.coord = $urandom_range(0, 1) ? (32'd0 - m) : m;
        end
        4, 5, 6: begin
          // integer and decimal parts that land on the header or escape byte
          case ($urandom_range(0, 4))
            0: m = 32'd94;
            1: m = 32'd93;
            2: m = 32'd350;
            3: m = 32'd15709;
            default: m = 32'd0;
          endcase
          m = m * 32'd100000;
          case ($urandom_range(0, 3))
            0: m = m + 32'd940;
            1: m = m + 32'd930;
            2: m = m + 32'd3490;
            default: m = m + 32'd6060;
          endcase
          m = m + $urandom_range(0, 9);
          r.coord = $urandom_range(0, 1) ? (32'd0 - m) : m;
        end
        default: ;
      endcase
    end else if (sel < 94) begin
      r.req = shtf_pkg::REQ_STOP;
    end else begin
      r.req = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("mismatch @%0d: %s exp %h got %h", cycle_count, what, want, got);
    mismatch_count++;
  endtask

  task automatic drive_request(input request_t r);
    int gap;
    gap = idle_cycles(send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_req_type = r.req;
    in_value_id = r.id;
    in_raw_value = r.raw;
    in_cell_index = r.cell_idx;
    in_cell_level = r.level;
    in_fuel_percent = r.fuel;
    in_coordinate = r.coord;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted_items++;
  endtask

  always @(posedge clk) begin : check_beats
    stream_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_stream.size() == 0) begin
        report_mismatch("beat with nothing pending, byte", 8'h00, out_byte);
      end else begin
        want = expected_stream.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", want.data, out_byte);
        if (out_last_byte !== want.last)
          report_mismatch("out_last_byte", {7'd0, want.last}, {7'd0, out_last_byte});
      end
    end
  end

  initial begin : receiver
    int stall_left;
    bit held_off;
    stall_left = 0;
    held_off = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && accepted_items >= HOLD_OFF_AT) begin
        // long back-pressure so the record queue fills and in_ready drops
        held_off = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        stall_left = idle_cycles(recv_quiet);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sensor_hub_telemetry_framer regression: fail");
    $finish;
  end

  initial begin : stimulus
    request_t r;
    int effective;
    mismatch_count = 0;
    accepted_items = 0;
    send_quiet = 0;
    recv_quiet = 0;
    effective = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = shtf_pkg::REQ_RAW;
    in_value_id = 8'h00;
    in_raw_value = 16'h0000;
    in_cell_index = 8'h00;
    in_cell_level = 12'h000;
    in_fuel_percent = 10'h000;
    in_coordinate = 32'sd0;

    directed_rows = '{
      '{'{shtf_pkg::REQ_STOP, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h0}, 1, 48'h5E0000000000},
      '{'{shtf_pkg::REQ_RAW, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h0}, 4, 48'h5E0000000000},
      '{'{shtf_pkg::REQ_RAW, 8'hFF, 16'hFFFF, 8'd0, 12'd0, 10'd0, 32'h0}, 4, 48'h5EFFFFFF0000},
      '{'{shtf_pkg::REQ_RAW, 8'h5E, 16'h5E5D, 8'd0, 12'd0, 10'd0, 32'h0}, 6, 48'h5E5E5D3D5D3E},
      '{'{shtf_pkg::REQ_CELL, 8'h00, 16'h0000, 8'd16, 12'd100, 10'd0, 32'h0}, 0, 48'h0},
      '{'{shtf_pkg::REQ_CELL, 8'h00, 16'h0000, 8'd255, 12'd0, 10'd0, 32'h0}, 0, 48'h0},
      '{'{REQ_SPARE6, 8'hFF, 16'hFFFF, 8'd0, 12'd0, 10'd0, 32'h0}, 0, 48'h0},
      '{'{REQ_SPARE7, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h0}, 0, 48'h0},
      '{'{shtf_pkg::REQ_CELL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h0}, 4, 48'h5E0600000000},
      '{'{shtf_pkg::REQ_CELL, 8'h00, 16'h0000, 8'd15, 12'd4095, 10'd0, 32'h0},
        4, 48'h5E06F8340000},
      '{'{shtf_pkg::REQ_CELL, 8'h00, 16'h0000, 8'd5, 12'd2100, 10'd0, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h0}, 4, 48'h5E0400000000},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd1023, 32'h0},
        4, 48'h5E0464000000},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd19, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd20, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd44, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd45, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd69, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd94, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_FUEL, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd95, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_LAT, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h0}, NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_LAT, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h80000000},
        NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_LON, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, -32'sd1800000000},
        NO_TYPED, 48'h0},
      '{'{shtf_pkg::REQ_LON, 8'h00, 16'h0000, 8'd0, 12'd0, 10'd0, 32'h7FFFFFFF},
        NO_TYPED, 48'h0}
    };

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      drive_request(directed_rows[i].rq);
      if (directed_rows[i].n_typed == NO_TYPED) begin
        frame_request(directed_rows[i].rq);
      end else begin
        frame_len = 0;
        for (int k = 0; k < directed_rows[i].n_typed; k++)
          push_byte(directed_rows[i].typed[47 - 8 * k -: 8]);
        close_frame();
      end
    end

    while (effective < RANDOM_ITEMS) begin
      r = random_request();
      drive_request(r);
      frame_request(r);
      if (frame_len > 0) effective++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_stream.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_stream.size() != 0)
      report_mismatch("beats never delivered, count", 8'(expected_stream.size()), 8'h00);

    if (mismatch_count == 0)
      $display("sensor_hub_telemetry_framer regression: pass");
    else
      $display("sensor_hub_telemetry_framer regression: fail");
    $finish;
  end

endmodule
